// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge.
`define ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// When the first expression holds, the second holds in the following cycle.
`define ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/farl_pkg.sv
// ----------------------------------------------------------------------------
// farl_pkg
// Types and constants shared by the record log controller and datapath.
// ----------------------------------------------------------------------------
package farl_pkg;

  localparam logic [31:0] ERASED    = 32'hFFFF_FFFF;
  localparam logic [31:0] HEAD_MARK = 32'h0000_0001;
  localparam logic [31:0] TAIL_MARK = 32'h0000_0004;

  localparam logic [1:0] ACT_OPEN = 2'd0;
  localparam logic [1:0] ACT_DATA = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ERASED  = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;
  localparam logic [1:0] ST_SEQERR  = 2'd3;

  typedef logic [3:0] op_t;
  localparam op_t OP_NONE       = 4'd0;
  localparam op_t OP_LOAD       = 4'd1;
  localparam op_t OP_CLR        = 4'd2;
  localparam op_t OP_ERR        = 4'd3;
  localparam op_t OP_RD_SCAN    = 4'd4;
  localparam op_t OP_DEC        = 4'd5;
  localparam op_t OP_ERASE_INIT = 4'd6;
  localparam op_t OP_ERASE      = 4'd7;
  localparam op_t OP_SETWP      = 4'd8;
  localparam op_t OP_WR_HEAD    = 4'd9;
  localparam op_t OP_WR_TAIL    = 4'd10;
  localparam op_t OP_WR_DATA    = 4'd11;
  localparam op_t OP_RINIT      = 4'd12;
  localparam op_t OP_RD_HEAD    = 4'd13;
  localparam op_t OP_FOUND      = 4'd14;
  localparam op_t OP_RD_DATA    = 4'd15;

  typedef struct packed {
    op_t  op;
    logic emit_st;
    logic emit_word;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       err_open;
    logic       err_len;
    logic       ws_zero;
    logic       scan_zero;
    logic       erased;
    logic       tail_hit;
    logic       head_hit;
    logic       need_erase;
    logic       erase_last;
    logic       clr_last;
    logic       wl_one;
    logic       rec_open;
    logic       out_valid;
    logic       out_last;
  } dp_sts_t;

endpackage

// File: hw/rtl/farl_ram.sv
// ----------------------------------------------------------------------------
// farl_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module farl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: hw/rtl/farl_datapath.sv
// ----------------------------------------------------------------------------
// farl_datapath
// Log store, pointers, scan counter and result register of the record log.
// ----------------------------------------------------------------------------
module farl_datapath #(
  parameter int PAGE_WORDS       = 256,
  parameter int MAX_PAGES        = 4,
  parameter int MAX_RECORD_WORDS = 63
) (
  input  logic              clk,
  input  logic              rst,
  input  farl_pkg::dp_cmd_t cmd,
  output farl_pkg::dp_sts_t sts,
  input  logic [2:0]        pages_in_use,
  input  logic [1:0]        in_action,
  input  logic [7:0]        in_bytes,
  input  logic [31:0]       in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [31:0]       out_word,
  output logic              out_last
);
  import farl_pkg::*;

  localparam int STORE_WORDS = PAGE_WORDS * MAX_PAGES;
  localparam int AW = $clog2(STORE_WORDS);
  localparam int SW = AW + 1;
  localparam int WX = SW + 1;

  logic [1:0]    action;
  logic [7:0]    bytes;
  logic [31:0]   data;
  logic [SW-1:0] scan;
  logic [SW-1:0] wp;
  logic [SW-1:0] base;
  logic [5:0]    idx;
  logic [5:0]    words_left;
  logic          record_open;
  logic [7:0]    open_size;
  logic [1:0]    st;
  logic          oob;

  logic [AW-1:0] addr;
  logic          we;
  logic [31:0]   wdata;
  logic [31:0]   rdata;

  logic [6:0]    ws;
  logic [WX-1:0] ws_x;
  logic [WX-1:0] scan_x;
  logic [WX-1:0] region_x;
  logic [SW-1:0] region;
  logic [WX-1:0] daddr;
  logic [31:0]   head;
  logic [31:0]   rtail;
  logic [31:0]   wtail;
  logic [31:0]   word;
  logic          fin;
  int            pc;

  farl_ram #(.WIDTH(32), .DEPTH(STORE_WORDS)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  always_comb begin
    pc = int'(pages_in_use);
    if (pc < 1) pc = 1;
    if (pc > MAX_PAGES) pc = MAX_PAGES;
    region   = SW'(pc * PAGE_WORDS);
    ws       = 7'((9'(bytes) + 9'd3) >> 2);
    ws_x     = WX'(ws);
    scan_x   = WX'(scan);
    region_x = WX'(region);
    daddr    = WX'(base) + WX'(idx);
    head     = {8'h00, bytes, 16'h0000} | HEAD_MARK;
    rtail    = {8'h00, bytes, 16'h0000} | TAIL_MARK;
    wtail    = {8'h00, open_size, 16'h0000} | TAIL_MARK;
    fin      = (7'(idx) == ws - 7'd1);
  end

  always_comb begin
    addr  = scan[AW-1:0];
    we    = 1'b0;
    wdata = ERASED;
    case (cmd.op)
      OP_CLR, OP_ERASE: we = 1'b1;
      OP_RD_SCAN: addr = AW'(scan - SW'(1));
      OP_RD_HEAD: addr = AW'(scan_x - ws_x - WX'(2));
      OP_RD_DATA: addr = daddr[AW-1:0];
      OP_WR_HEAD: begin
        addr = wp[AW-1:0];
        we = (wp < SW'(STORE_WORDS));
        wdata = head;
      end
      OP_WR_TAIL: begin
        addr = wp[AW-1:0];
        we = (wp < SW'(STORE_WORDS));
        wdata = wtail;
      end
      OP_WR_DATA: begin
        addr = wp[AW-1:0];
        we = (wp < SW'(STORE_WORDS));
        wdata = data;
      end
      default: ;
    endcase
  end

  always_comb begin
    word = oob ? ERASED : rdata;
    if (fin) begin
      case (bytes[1:0])
        2'd1: word = word & 32'h0000_00FF;
        2'd2: word = word & 32'h0000_FFFF;
        2'd3: word = word & 32'h00FF_FFFF;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan        <= '0;
      wp          <= '0;
      words_left  <= '0;
      record_open <= 1'b0;
      open_size   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        OP_LOAD: begin
          action <= in_action;
          bytes  <= in_bytes;
          data   <= in_data;
          scan   <= region;
        end
        OP_CLR, OP_ERASE: scan <= scan + SW'(1);
        OP_ERR: st <= ST_SEQERR;
        OP_DEC: scan <= scan - SW'(1);
        OP_ERASE_INIT: begin
          scan <= '0;
          wp   <= '0;
          st   <= ST_ERASED;
        end
        OP_SETWP: begin
          wp <= scan;
          st <= ST_OK;
        end
        OP_WR_HEAD: begin
          wp          <= wp + SW'(1);
          open_size   <= bytes;
          words_left  <= 6'(ws);
          record_open <= (ws != 7'd0);
        end
        OP_WR_TAIL: begin
          wp          <= wp + SW'(1);
          record_open <= 1'b0;
        end
        OP_WR_DATA: begin
          wp         <= wp + SW'(1);
          words_left <= words_left - 6'd1;
          st         <= ST_OK;
        end
        OP_RINIT: begin
          st   <= ST_MISSING;
          base <= '0;
          idx  <= '0;
        end
        OP_FOUND: begin
          st   <= ST_OK;
          base <= SW'(scan_x - WX'(1) - ws_x);
          idx  <= '0;
        end
        OP_RD_DATA: oob <= (daddr >= WX'(STORE_WORDS));
        default: ;
      endcase
      if (cmd.emit_st) begin
        out_valid  <= 1'b1;
        out_status <= st;
        out_word   <= '0;
        out_last   <= 1'b1;
      end
      if (cmd.emit_word) begin
        out_valid  <= 1'b1;
        out_status <= st;
        out_word   <= word;
        out_last   <= fin;
        idx        <= idx + 6'd1;
      end
    end
  end

  always_comb begin
    sts.action     = action;
    sts.err_open   = record_open || (ws > 7'(MAX_RECORD_WORDS)) ||
                     (ws_x + WX'(2) > region_x);
    sts.err_len    = (ws > 7'(MAX_RECORD_WORDS));
    sts.ws_zero    = (ws == 7'd0);
    sts.scan_zero  = (scan == '0);
    sts.erased     = (rdata == ERASED);
    sts.tail_hit   = (rdata == rtail) && (scan_x >= ws_x + WX'(2));
    sts.head_hit   = (rdata == head);
    sts.need_erase = ((region_x - scan_x) < ws_x + WX'(2));
    sts.erase_last = (scan == region - SW'(1));
    sts.clr_last   = (scan == SW'(STORE_WORDS - 1));
    sts.wl_one     = (words_left == 6'd1);
    sts.rec_open   = record_open;
    sts.out_valid  = out_valid;
    sts.out_last   = out_last;
  end

endmodule

// File: hw/rtl/farl_ctrl.sv
// ----------------------------------------------------------------------------
// farl_ctrl
// Sequencer for clearing, opening, appending and reading records.
// ----------------------------------------------------------------------------
module farl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  input  farl_pkg::dp_sts_t sts,
  output farl_pkg::dp_cmd_t cmd
);
  import farl_pkg::*;
  `include "assert_macros.svh"

  localparam logic [4:0] S_CLEAR  = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_DISP   = 5'd2;
  localparam logic [4:0] S_OSCAN  = 5'd3;
  localparam logic [4:0] S_OCHK   = 5'd4;
  localparam logic [4:0] S_DECIDE = 5'd5;
  localparam logic [4:0] S_ERASE  = 5'd6;
  localparam logic [4:0] S_WHEAD  = 5'd7;
  localparam logic [4:0] S_WTAIL  = 5'd8;
  localparam logic [4:0] S_EMIT   = 5'd9;
  localparam logic [4:0] S_RSCAN  = 5'd10;
  localparam logic [4:0] S_RCHK   = 5'd11;
  localparam logic [4:0] S_HCHK   = 5'd12;
  localparam logic [4:0] S_RSTART = 5'd13;
  localparam logic [4:0] S_RDATA  = 5'd14;
  localparam logic [4:0] S_RWORD  = 5'd15;
  localparam logic [4:0] S_OUT    = 5'd16;

  logic [4:0] state;
  logic [4:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    cmd.op        = OP_NONE;
    cmd.emit_st   = 1'b0;
    cmd.emit_word = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.op = OP_CLR;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        state_next = S_EMIT;
        case (sts.action)
          ACT_OPEN: begin
            if (sts.err_open) cmd.op = OP_ERR;
            else state_next = S_OSCAN;
          end
          ACT_DATA: begin
            if (!sts.rec_open) begin
              cmd.op = OP_ERR;
            end else begin
              cmd.op = OP_WR_DATA;
              if (sts.wl_one) state_next = S_WTAIL;
            end
          end
          ACT_READ: begin
            if (sts.err_len) begin
              cmd.op = OP_ERR;
            end else begin
              cmd.op = OP_RINIT;
              state_next = S_RSCAN;
            end
          end
          default: cmd.op = OP_ERR;
        endcase
      end
      S_OSCAN: begin
        if (sts.scan_zero) begin
          state_next = S_DECIDE;
        end else begin
          cmd.op = OP_RD_SCAN;
          state_next = S_OCHK;
        end
      end
      S_OCHK: begin
        if (sts.erased) begin
          cmd.op = OP_DEC;
          state_next = S_OSCAN;
        end else begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.need_erase) begin
          cmd.op = OP_ERASE_INIT;
          state_next = S_ERASE;
        end else begin
          cmd.op = OP_SETWP;
          state_next = S_WHEAD;
        end
      end
      S_ERASE: begin
        cmd.op = OP_ERASE;
        if (sts.erase_last) state_next = S_WHEAD;
      end
      S_WHEAD: begin
        cmd.op = OP_WR_HEAD;
        state_next = sts.ws_zero ? S_WTAIL : S_EMIT;
      end
      S_WTAIL: begin
        cmd.op = OP_WR_TAIL;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit_st = 1'b1;
        state_next = S_OUT;
      end
      S_RSCAN: begin
        if (sts.scan_zero) begin
          state_next = S_RSTART;
        end else begin
          cmd.op = OP_RD_SCAN;
          state_next = S_RCHK;
        end
      end
      S_RCHK: begin
        if (sts.tail_hit) begin
          cmd.op = OP_RD_HEAD;
          state_next = S_HCHK;
        end else begin
          cmd.op = OP_DEC;
          state_next = S_RSCAN;
        end
      end
      S_HCHK: begin
        if (sts.head_hit) begin
          cmd.op = OP_FOUND;
          state_next = S_RSTART;
        end else begin
          cmd.op = OP_DEC;
          state_next = S_RSCAN;
        end
      end
      S_RSTART: begin
        state_next = sts.ws_zero ? S_EMIT : S_RDATA;
      end
      S_RDATA: begin
        cmd.op = OP_RD_DATA;
        state_next = S_RWORD;
      end
      S_RWORD: begin
        cmd.emit_word = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (sts.out_valid && out_ready) begin
          state_next = sts.out_last ? S_IDLE : S_RDATA;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  `ASSERT_ALWAYS(a_out_holds_result, (state != S_OUT) || sts.out_valid)
  `ASSERT_NEXT(a_emit_sets_valid, cmd.emit_st || cmd.emit_word, sts.out_valid)
  `ASSERT_NEXT(a_clear_runs, (state == S_CLEAR) && !sts.clr_last, state == S_CLEAR)

endmodule

// File: hw/rtl/flash_append_record_log.sv
// ----------------------------------------------------------------------------
// flash_append_record_log
// Append-only record log kept in an erase-to-ones word store.
// ----------------------------------------------------------------------------
// Usage: commands enter on the s_ stream (s_tuser = action, s_tdata =
// record_bytes then data_word) and results leave on the m_ stream (m_tuser =
// status, m_tdata = read_word, m_tlast = last). One command is handled at a
// time; s_tready is high only while the block is idle.
// An open scans the active region downward from the top past erased words,
// and may then erase the region before it writes the head. A read scans the
// region downward from the top, checks the head of each candidate tail, then
// delivers each record word, waiting for m_tready after each. The single
// store port serializes this work.
// After reset the whole store of PAGE_WORDS*MAX_PAGES words is cleared to
// ones, one word a cycle, before the first command is taken; the APB
// register port works throughout. When the receiver stalls, the result holds
// on the m_ stream and no further work proceeds until it is taken.
// ----------------------------------------------------------------------------
module flash_append_record_log #(
  parameter int PAGE_WORDS       = 256,
  parameter int MAX_PAGES        = 4,
  parameter int MAX_RECORD_WORDS = 63
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // record_bytes[7:0], data_word[39:8]
  input  logic [1:0]  s_tuser,   // action[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // read_word[31:0]
  output logic [1:0]  m_tuser,   // status[1:0]
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import farl_pkg::*;

  logic [2:0] pages_in_use;
  dp_cmd_t    cmd;
  dp_sts_t    sts;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {29'd0, pages_in_use} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pages_in_use <= 3'd1;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      pages_in_use <= pwdata[2:0];
    end
  end

  farl_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .out_ready(m_tready), .sts(sts), .cmd(cmd)
  );

  farl_datapath #(
    .PAGE_WORDS(PAGE_WORDS), .MAX_PAGES(MAX_PAGES),
    .MAX_RECORD_WORDS(MAX_RECORD_WORDS)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .pages_in_use(pages_in_use),
    .in_action(s_tuser), .in_bytes(s_tdata[7:0]), .in_data(s_tdata[39:8]),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_status(m_tuser),
    .out_word(m_tdata), .out_last(m_tlast)
  );

endmodule
